>>> rtl/metp_pkg.sv
// shared types, constants and control program of the mandelbrot escape-time pixel unit
package metp_pkg;

    // number format and field widths
    localparam int CANVAS_SIZE = 2048;
    localparam int FRAC_BITS   = 28;
    localparam int INDEX_W     = 11;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 31;
    localparam int LIMIT_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int LEVEL_W     = 8;

    // multiplier and accumulator widths
    localparam int MAG_W   = 31;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int FX_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W   = FX_W + 3;
    localparam int CPROD_W = INDEX_W + STEP_W;
    localparam int CSUM_W  = CPROD_W + 2;
    localparam int NUM_MUL = 3;

    // color caps
    localparam logic [LIMIT_W-1:0] GREEN_CAP = LIMIT_W'(200);
    localparam logic [LIMIT_W-1:0] BLUE_CAP  = LIMIT_W'(20);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);

    // configuration register map
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ITERATION_LIMIT = 3'd0,
        REG_REAL_ORIGIN     = 3'd1,
        REG_IMAG_ORIGIN     = 3'd2,
        REG_REAL_STEP       = 3'd3,
        REG_IMAG_STEP       = 3'd4,
        REG_COLOR_SCALE     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]        iteration_limit;
        logic signed [COORD_W-1:0] real_origin;
        logic signed [COORD_W-1:0] imag_origin;
        logic [STEP_W-1:0]         real_step;
        logic [STEP_W-1:0]         imag_step;
        logic [SCALE_W-1:0]        color_scale;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        iteration_limit: 16'd20000,
        real_origin:     -32'sd536870912,
        imag_origin:     -32'sd150323855,
        real_step:       31'd331518,
        imag_step:       31'd150324,
        color_scale:     16'd8356
    };

    // one result
    typedef struct packed {
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
        logic               escaped;
        logic [LIMIT_W-1:0] iteration_count;
    } res_t;

    // microcode
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_MUL_COORD,
        OP_SET_COORD,
        OP_MUL_ITER,
        OP_ITER,
        OP_MUL_COLOR,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_REQ,
        COND_CONTINUE,
        COND_OUT_BUSY
    } cond_t;

    localparam int UPC_W    = 3;
    localparam int PROG_LEN = 7;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t STEP_IDLE     = 3'd0;
    localparam upc_t STEP_MUL_ITER = 3'd3;
    localparam upc_t STEP_EMIT     = 3'd6;
    localparam upc_t STEP_LAST     = 3'd6;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // jump to target when the condition holds, otherwise fall through
    localparam uword_t UCODE [PROG_LEN] = '{
        '{op: OP_ACCEPT,    cond: COND_NO_REQ,   target: STEP_IDLE},
        '{op: OP_MUL_COORD, cond: COND_NONE,     target: STEP_IDLE},
        '{op: OP_SET_COORD, cond: COND_NONE,     target: STEP_IDLE},
        '{op: OP_MUL_ITER,  cond: COND_NONE,     target: STEP_IDLE},
        '{op: OP_ITER,      cond: COND_CONTINUE, target: STEP_MUL_ITER},
        '{op: OP_MUL_COLOR, cond: COND_NONE,     target: STEP_IDLE},
        '{op: OP_EMIT,      cond: COND_OUT_BUSY, target: STEP_EMIT}
    };

endpackage

>>> rtl/metp_datapath.sv
// arithmetic datapath of the escape-time unit: three shared multipliers and the z update
module metp_datapath
(
    input  logic                          clk,
    input  metp_pkg::cfg_t                cfg,
    input  metp_pkg::op_t                 op,
    input  logic [metp_pkg::INDEX_W-1:0]  real_index,
    input  logic [metp_pkg::INDEX_W-1:0]  imag_index,
    output logic                          iter_exit,
    output metp_pkg::res_t                res
);
    import metp_pkg::*;

    localparam logic signed [ACC_W-1:0] FOUR_S =
        ACC_W'(longint'(1) << (FRAC_BITS + 2));
    localparam logic [FX_W:0] FOUR_U = (FX_W + 1)'(longint'(1) << (FRAC_BITS + 2));
    localparam logic signed [CSUM_W-1:0] COORD_MAX =
        CSUM_W'((longint'(1) << (COORD_W - 1)) - 1);

    logic [INDEX_W-1:0]        real_index_reg;
    logic [INDEX_W-1:0]        imag_index_reg;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [LIMIT_W-1:0]        count_reg;
    logic                      esc_reg;
    logic                      xy_neg_reg;
    logic [PROD_W-1:0]         prod_reg [NUM_MUL];

    logic [MAG_W-1:0]          op_a [NUM_MUL];
    logic [MAG_W-1:0]          op_b [NUM_MUL];
    logic [PROD_W-1:0]         prod_next [NUM_MUL];
    logic [COORD_W-1:0]        abs_x;
    logic [COORD_W-1:0]        abs_y;
    logic [LIMIT_W-1:0]        green_n;
    logic [LIMIT_W-1:0]        blue_n;
    logic [FX_W-1:0]           xy_mag;
    logic [FX_W-1:0]           xx;
    logic [FX_W-1:0]           yy;
    logic signed [ACC_W-1:0]   xy_s;
    logic signed [ACC_W-1:0]   ny_raw;
    logic signed [ACC_W-1:0]   nx_raw;
    logic [FX_W:0]             mag2;
    logic                      escape_now;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;
    logic signed [COORD_W-1:0] cr_next;
    logic signed [COORD_W-1:0] ci_next;

    function automatic logic signed [COORD_W-1:0] clamp_four(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        begin
            if (v > FOUR_S)
            begin
                c = FOUR_S;
            end
            else if (v < -FOUR_S)
            begin
                c = -FOUR_S;
            end
            else
            begin
                c = v;
            end
            return c[COORD_W-1:0];
        end
    endfunction

    // origin + index * step, the product is never negative so only the top saturates
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W-1:0] origin,
        input logic [CPROD_W-1:0]        offset
    );
        logic signed [CSUM_W-1:0] s;
        begin
            s = $signed({{(CSUM_W - COORD_W){origin[COORD_W-1]}}, origin})
              + $signed({{(CSUM_W - CPROD_W){1'b0}}, offset});
            if (s > COORD_MAX)
            begin
                s = COORD_MAX;
            end
            return s[COORD_W-1:0];
        end
    endfunction

    function automatic logic [LEVEL_W-1:0] level(input logic [PROD_W-1:0] p);
        logic [LIMIT_W-1:0] v;
        begin
            v = p[LIMIT_W+SCALE_W-1:SCALE_W];
            return (v > LIMIT_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
        end
    endfunction

    assign abs_x   = x_reg[COORD_W-1] ? COORD_W'(-x_reg) : COORD_W'(x_reg);
    assign abs_y   = y_reg[COORD_W-1] ? COORD_W'(-y_reg) : COORD_W'(y_reg);
    assign green_n = (count_reg < GREEN_CAP) ? count_reg : GREEN_CAP;
    assign blue_n  = (count_reg < BLUE_CAP) ? count_reg : BLUE_CAP;

    // operand select for the three multipliers
    always_comb
    begin
        for (int k = 0; k < NUM_MUL; k++)
        begin
            op_a[k] = '0;
            op_b[k] = '0;
        end
        case (op)
            OP_MUL_COORD:
            begin
                op_a[0] = MAG_W'(real_index_reg % CANVAS_SIZE);
                op_b[0] = MAG_W'(cfg.real_step);
                op_a[1] = MAG_W'(imag_index_reg % CANVAS_SIZE);
                op_b[1] = MAG_W'(cfg.imag_step);
            end
            OP_MUL_ITER:
            begin
                op_a[0] = abs_x[MAG_W-1:0];
                op_b[0] = abs_y[MAG_W-1:0];
                op_a[1] = abs_x[MAG_W-1:0];
                op_b[1] = abs_x[MAG_W-1:0];
                op_a[2] = abs_y[MAG_W-1:0];
                op_b[2] = abs_y[MAG_W-1:0];
            end
            OP_MUL_COLOR:
            begin
                op_a[0] = MAG_W'(count_reg);
                op_a[1] = MAG_W'(green_n);
                op_a[2] = MAG_W'(blue_n);
                op_b[0] = MAG_W'(cfg.color_scale);
                op_b[1] = MAG_W'(cfg.color_scale);
                op_b[2] = MAG_W'(cfg.color_scale);
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < NUM_MUL; k++)
        begin
            prod_next[k] = PROD_W'(op_a[k]) * PROD_W'(op_b[k]);
        end
    end

    // fixed-point products truncate toward zero: shift the magnitude, then apply the sign
    assign xy_mag = prod_reg[0][PROD_W-1:FRAC_BITS];
    assign xx     = prod_reg[1][PROD_W-1:FRAC_BITS];
    assign yy     = prod_reg[2][PROD_W-1:FRAC_BITS];

    always_comb
    begin
        xy_s   = $signed({3'b000, xy_mag});
        if (xy_neg_reg)
        begin
            xy_s = -xy_s;
        end
        ny_raw = (xy_s <<< 1)
               + $signed({{(ACC_W - COORD_W){ci_reg[COORD_W-1]}}, ci_reg});
        nx_raw = $signed({3'b000, xx}) - $signed({3'b000, yy})
               + $signed({{(ACC_W - COORD_W){cr_reg[COORD_W-1]}}, cr_reg});
        x_next = clamp_four(nx_raw);
        y_next = clamp_four(ny_raw);
        mag2   = {1'b0, xx} + {1'b0, yy};
    end

    assign escape_now = mag2 > FOUR_U;
    assign iter_exit  = escape_now || (count_reg >= cfg.iteration_limit);
    assign cr_next    = sat_coord(cfg.real_origin, prod_reg[0][CPROD_W-1:0]);
    assign ci_next    = sat_coord(cfg.imag_origin, prod_reg[1][CPROD_W-1:0]);

    always_ff @(posedge clk)
    begin
        case (op)
            OP_ACCEPT:
            begin
                real_index_reg <= real_index;
                imag_index_reg <= imag_index;
            end
            OP_MUL_COORD, OP_MUL_ITER, OP_MUL_COLOR:
            begin
                for (int k = 0; k < NUM_MUL; k++)
                begin
                    prod_reg[k] <= prod_next[k];
                end
                xy_neg_reg <= x_reg[COORD_W-1] ^ y_reg[COORD_W-1];
            end
            OP_SET_COORD:
            begin
                cr_reg    <= cr_next;
                ci_reg    <= ci_next;
                x_reg     <= '0;
                y_reg     <= '0;
                count_reg <= '0;
            end
            OP_ITER:
            begin
                if (iter_exit)
                begin
                    esc_reg <= escape_now;
                end
                else
                begin
                    x_reg     <= x_next;
                    y_reg     <= y_next;
                    count_reg <= count_reg + LIMIT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.iteration_count = count_reg;
    assign res.escaped         = esc_reg;
    assign res.red_level       = level(prod_reg[0]);
    assign res.green_level     = level(prod_reg[1]);
    assign res.blue_level      = level(prod_reg[2]);

endmodule

>>> rtl/mandelbrot_escape_time_pixel_unit.sv
// top level of the mandelbrot escape-time pixel unit: sequencer, registers, stream ports
//
// Each request on the slave stream names one pixel by a real and an imaginary index.
// The unit forms c = origin + index * step in signed Q4.28 (saturated to 32 bits),
// iterates z = z*z + c from zero until |z|^2 exceeds 4 or iteration_limit is
// reached, and returns the iteration count, an escaped flag and red, green and blue
// levels, each min(count, cap) * color_scale / 2^16 saturated at 255 (no cap for
// red, 200 for green, 20 for blue). Work is run by a seven-step microcode program
// driving three shared 31x31 multipliers. A pixel is accepted, its coordinates are
// formed, and each iteration passes through the multiplier output register and the
// z update; a final escape test is followed by the color and emit steps, and the
// emit step holds while the output register is still occupied. A finished result
// waits in the output register, so the next request is taken while the previous
// result is still pending. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and must only change while the unit is idle.
module mandelbrot_escape_time_pixel_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    // pixel requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // real_index[10:0], imag_index[21:11]

    // pixel results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // iteration_count[15:0], escaped[16],
                                                         // red_level[24:17], green_level[32:25],
                                                         // blue_level[40:33]

    // configuration writes
    input  logic                              cfg_write,
    input  logic [metp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [metp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import metp_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uword;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic [47:0] m_tdata_reg;
    logic [47:0] m_tdata_next;
    logic   iter_exit;
    logic   out_busy;
    logic   emit_load;
    logic   jump;
    res_t   res;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ITERATION_LIMIT: cfg_next.iteration_limit = cfg_data[LIMIT_W-1:0];
                REG_REAL_ORIGIN:     cfg_next.real_origin     = cfg_data[COORD_W-1:0];
                REG_IMAG_ORIGIN:     cfg_next.imag_origin     = cfg_data[COORD_W-1:0];
                REG_REAL_STEP:       cfg_next.real_step       = cfg_data[STEP_W-1:0];
                REG_IMAG_STEP:       cfg_next.imag_step       = cfg_data[STEP_W-1:0];
                REG_COLOR_SCALE:     cfg_next.color_scale     = cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // microcode sequencer: current control word straight from the program table
    assign uword    = UCODE[upc_reg];
    assign s_tready = (uword.op == OP_ACCEPT);
    assign out_busy = m_tvalid_reg && !m_tready;

    always_comb
    begin
        unique case (uword.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_REQ:   jump = !s_tvalid;    // hold in idle until a request arrives
            COND_CONTINUE: jump = !iter_exit;   // loop back to the multiply step
            COND_OUT_BUSY: jump = out_busy;     // hold the result until the slot frees
            default:       jump = 1'b0;
        endcase
        if (jump)
        begin
            upc_next = uword.target;
        end
        else if (upc_reg == STEP_LAST)
        begin
            upc_next = STEP_IDLE;
        end
        else
        begin
            upc_next = upc_t'(upc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    metp_datapath u_datapath
    (
        .clk        (clk),
        .cfg        (cfg_reg),
        .op         (uword.op),
        .real_index (s_tdata[INDEX_W-1:0]),
        .imag_index (s_tdata[2*INDEX_W-1:INDEX_W]),
        .iter_exit  (iter_exit),
        .res        (res)
    );

    // output register, loaded on the emit step when the slot is free
    assign emit_load = (uword.op == OP_EMIT) && !out_busy;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        m_tdata_next = m_tdata_reg;
        if (emit_load)
        begin
            m_tdata_next = {7'b0000000, res.blue_level, res.green_level, res.red_level,
                            res.escaped, res.iteration_count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the mandelbrot escape-time pixel unit
`timescale 1ns / 100ps

module tb_top;

    import metp_pkg::*;

    // fixed-point format of the coordinates and of z
    localparam int FRACTION = 28;
    // generous bound on the whole run, several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // one pixel request, real index in the low bits
    typedef struct packed {
        logic [10:0] imag_index;
        logic [10:0] real_index;
    } pixel_req_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // pixels waiting to be offered, results still owed by the unit
    pixel_req_t  pending_pixels[$];
    res_t        expected_results[$];

    // register values as the unit should hold them (reset values)
    cfg_t        view_cfg = '{
        iteration_limit: 16'd20000,
        real_origin:     -32'sd536870912,
        imag_origin:     -32'sd150323855,
        real_step:       31'd331518,
        imag_step:       31'd150324,
        color_scale:     16'd8356
    };

    logic        req_fire       = 1'b0;
    logic        no_gaps        = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    mandelbrot_escape_time_pixel_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // escape-time predictor
    // ---------------------------------------------------------------

    // fixed-point product, truncated toward zero
    function automatic longint fixed_mul(input longint a, input longint b);
        longint ua;
        longint ub;
        longint p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p  = (ua * ub) >> FRACTION;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // z components are held within +-4.0
    function automatic longint clamp_four(input longint v);
        longint four;
        four = longint'(4) << FRACTION;
        if (v > four)
            return four;
        if (v < -four)
            return -four;
        return v;
    endfunction

    // origin + index * step, saturated to the signed 32-bit range
    function automatic longint pixel_coord(input longint origin, input longint step,
                                           input logic [10:0] index);
        longint v;
        v = origin + longint'(index) * step;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    // min(count, cap) * scale / 2^16, saturated at full level
    function automatic logic [7:0] color_level(input longint count, input longint cap);
        longint n;
        longint v;
        n = (count < cap) ? count : cap;
        v = (n * longint'(view_cfg.color_scale)) >> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic res_t escape_time(input pixel_req_t px);
        longint four;
        longint cr;
        longint ci;
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint nx;
        longint ny;
        longint count;
        res_t   r;
        four  = longint'(4) << FRACTION;
        cr    = pixel_coord(longint'($signed(view_cfg.real_origin)),
                            longint'(view_cfg.real_step), px.real_index);
        ci    = pixel_coord(longint'($signed(view_cfg.imag_origin)),
                            longint'(view_cfg.imag_step), px.imag_index);
        x     = 0;
        y     = 0;
        x2    = 0;
        y2    = 0;
        count = 0;
        while (x2 + y2 <= four && count < longint'(view_cfg.iteration_limit))
        begin
            ny    = clamp_four(2 * fixed_mul(x, y) + ci);
            nx    = clamp_four(x2 - y2 + cr);
            x     = nx;
            y     = ny;
            x2    = fixed_mul(x, x);
            y2    = fixed_mul(y, y);
            count = count + 1;
        end
        r.iteration_count = count[15:0];
        r.escaped         = (x2 + y2 > four);
        r.red_level       = color_level(count, 64'h0000_0000_FFFF_FFFF);
        r.green_level     = color_level(count, 200);
        r.blue_level      = color_level(count, 20);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending pixels, drives the result-side ready
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        // load the next request once the current one is gone or none is up
        if (rst_n && (!s_tvalid || req_fire))
        begin
            if (pending_pixels.size() != 0 && (no_gaps || $urandom_range(99) >= 6))
            begin
                s_tdata  <= {2'b00, pending_pixels.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        // result-side stalls, none during the steady stretch
        m_tready <= rst_n && (no_gaps || $urandom_range(99) >= 6);
    end

    // ---------------------------------------------------------------
    // monitor: predicts on each accepted request, checks each result
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n)
        begin
            req_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(escape_time(pixel_req_t'(s_tdata[21:0])));
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[40:0]);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing owed: count %0d escaped %0d rgb %0d/%0d/%0d",
                             $time, got.iteration_count, got.escaped,
                             got.red_level, got.green_level, got.blue_level);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.iteration_count !== want.iteration_count ||
                        got.escaped !== want.escaped ||
                        got.red_level !== want.red_level ||
                        got.green_level !== want.green_level ||
                        got.blue_level !== want.blue_level ||
                        m_tdata[47:41] !== 7'd0)
                    begin
                        $display("%0t: result mismatch: expected count %0d escaped %0d rgb %0d/%0d/%0d, actual count %0d escaped %0d rgb %0d/%0d/%0d pad %0h",
                                 $time, want.iteration_count, want.escaped,
                                 want.red_level, want.green_level, want.blue_level,
                                 got.iteration_count, got.escaped,
                                 got.red_level, got.green_level, got.blue_level,
                                 m_tdata[47:41]);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results still owed", $time,
                     expected_results.size());
            $display("mandelbrot_escape_time_pixel_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_pixel(input int unsigned ri, input int unsigned ii);
        pixel_req_t px;
        px.real_index = ri[10:0];
        px.imag_index = ii[10:0];
        pending_pixels.push_back(px);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // writes all six registers back to back, unit must be idle
    task automatic apply_settings(input logic [15:0] limit, input logic [31:0] real_o,
                                  input logic [31:0] imag_o, input logic [30:0] real_s,
                                  input logic [30:0] imag_s, input logic [15:0] scale);
        write_reg(REG_ITERATION_LIMIT, {16'd0, limit});
        write_reg(REG_REAL_ORIGIN, real_o);
        write_reg(REG_IMAG_ORIGIN, imag_o);
        write_reg(REG_REAL_STEP, {1'b0, real_s});
        write_reg(REG_IMAG_STEP, {1'b0, imag_s});
        write_reg(REG_COLOR_SCALE, {16'd0, scale});
        @(negedge clk);
        cfg_write <= 1'b0;
        view_cfg.iteration_limit = limit;
        view_cfg.real_origin     = real_o;
        view_cfg.imag_origin     = imag_o;
        view_cfg.real_step       = real_s;
        view_cfg.imag_step       = imag_s;
        view_cfg.color_scale     = scale;
    endtask

    // every request offered, every result back, unit back in idle
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [15:0] limit;
        logic [31:0] real_o;
        logic [31:0] imag_o;
        logic [30:0] real_s;
        logic [30:0] imag_s;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: corner pixel escapes at once, pixel near zero is inside,
        // inside point saturates red
        queue_pixel(0, 0);
        queue_pixel(2047, 2047);
        queue_pixel(1620, 1000);
        wait_drained();

        // largest limit and largest scale, full-length inside point
        apply_settings(16'hFFFF, -32'sd536870912, -32'sd150323855, 31'd331518,
                       31'd150324, 16'hFFFF);
        queue_pixel(1620, 1000);
        queue_pixel(0, 0);
        queue_pixel(2047, 0);
        wait_drained();

        // zero limit: no iteration at all, zero scale
        apply_settings(16'd0, -32'sd536870912, -32'sd150323855, 31'd331518,
                       31'd150324, 16'd0);
        queue_pixel(0, 0);
        queue_pixel(2047, 2047);
        wait_drained();

        // c = 1.0 escapes on its third iteration, which is the last allowed one;
        // z runs past 4.0 and gets clamped on the way
        apply_settings(16'd3, 32'h1000_0000, 32'd0, 31'd0, 31'd0, 16'd40000);
        queue_pixel(5, 7);
        queue_pixel(0, 0);
        wait_drained();

        // coordinates saturate at the top of the signed range
        apply_settings(16'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                       31'h7FFF_FFFF, 16'hFFFF);
        queue_pixel(2047, 2047);
        queue_pixel(0, 0);
        queue_pixel(1, 1024);
        wait_drained();

        // most negative origins, zero steps
        apply_settings(16'd5, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 16'd12345);
        queue_pixel(1234, 777);
        queue_pixel(2047, 0);
        wait_drained();

        // random windows, mostly over the interesting part of the plane
        for (int p = 0; p < 6; p++)
        begin
            limit = (p == 5) ? 16'($urandom_range(2000, 1000)) : 16'($urandom_range(400, 1));
            if ($urandom_range(99) < 80)
            begin
                // real in [-2.5, 0.5], imag in [-1.5, 1.5], span up to 4.0
                real_o = 32'(-671088640 + int'($urandom_range(805306368, 0)));
                imag_o = 32'(-402653184 + int'($urandom_range(805306368, 0)));
                real_s = 31'($urandom_range(1 << 19, 0));
                imag_s = 31'($urandom_range(1 << 19, 0));
            end
            else
            begin
                // anywhere in the number range
                real_o = $urandom();
                imag_o = $urandom();
                real_s = 31'($urandom());
                imag_s = 31'($urandom());
            end
            apply_settings(limit, real_o, imag_o, real_s, imag_s,
                           16'($urandom_range(65535, 0)));
            // one window runs without any idling on either side
            no_gaps = (p == 2);
            repeat (17)
                queue_pixel($urandom_range(2047, 0), $urandom_range(2047, 0));
            wait_drained();
            no_gaps = 1'b0;
        end

        // catch any stray result
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("mandelbrot_escape_time_pixel_unit regression: pass");
        else
            $display("mandelbrot_escape_time_pixel_unit regression: fail");
        $finish;
    end

endmodule
